@@ rtl/core/jtag_tap_navigator_shifter_macros.svh @@
// Assertion macros used by the TAP navigator top level.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef JTAG_TAP_NAVIGATOR_SHIFTER_MACROS_SVH
`define JTAG_TAP_NAVIGATOR_SHIFTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JTN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JTN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/jtn_pkg.sv @@
// Shared types, constants and functions of the TAP navigator.
// Holds TAP state codes, transition and path rules, and the microcode ROM.
`timescale 1ns / 1ps

package jtn_pkg;

  localparam int ResetOnes = 5;
  localparam int MaxPulses = 8;
  localparam int UpcW      = 4;
  localparam int CntW      = $clog2(MaxPulses);

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_GOTO  = 2'd1,
    OP_SHIFT = 2'd2,
    OP_IDLE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    TAP_RESET  = 4'd0,
    TAP_IDLE   = 4'd1,
    TAP_SEL_DR = 4'd2,
    TAP_CAP_DR = 4'd3,
    TAP_SH_DR  = 4'd4,
    TAP_EX1_DR = 4'd5,
    TAP_PAU_DR = 4'd6,
    TAP_EX2_DR = 4'd7,
    TAP_UPD_DR = 4'd8,
    TAP_SEL_IR = 4'd9,
    TAP_CAP_IR = 4'd10,
    TAP_SH_IR  = 4'd11,
    TAP_EX1_IR = 4'd12,
    TAP_PAU_IR = 4'd13,
    TAP_EX2_IR = 4'd14,
    TAP_UPD_IR = 4'd15
  } tap_state_t;

  typedef enum logic [1:0] {
    TMS_ZERO = 2'd0,
    TMS_ONE  = 2'd1,
    TMS_LAST = 2'd2,
    TMS_PATH = 2'd3
  } tms_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,
    JMP_LOOP = 2'd1,
    JMP_DONE = 2'd2
  } jmp_t;

  typedef struct packed {
    tms_sel_t tms_sel;
    logic     use_data;     // drive TDI and check fields from the request
    logic     emit_if_away; // emit only while not yet at the target
    jmp_t     jmp;
  } ctrl_t;

  typedef struct packed {
    logic emit;
    logic run_end;
  } seq_stat_t;

  typedef struct packed {
    logic slot_free;
    logic pos_at_tgt;
    logic nxt_at_tgt;
  } dp_stat_t;

  localparam logic [UpcW-1:0] AddrReset     = '0;
  localparam logic [UpcW-1:0] AddrResetLast = UpcW'(ResetOnes);
  localparam logic [UpcW-1:0] AddrGoto      = UpcW'(ResetOnes + 1);
  localparam logic [UpcW-1:0] AddrShift     = UpcW'(ResetOnes + 2);
  localparam logic [UpcW-1:0] AddrIdle      = UpcW'(ResetOnes + 3);

  function automatic logic [UpcW-1:0] entry_addr(op_t op);
    logic [UpcW-1:0] a;
    case (op)
      OP_RESET: a = AddrReset;
      OP_GOTO:  a = AddrGoto;
      OP_SHIFT: a = AddrShift;
      OP_IDLE:  a = AddrIdle;
      default:  a = AddrIdle;
    endcase
    return a;
  endfunction

  // Microcode ROM: one control word per step.
  function automatic ctrl_t ucode(logic [UpcW-1:0] upc);
    ctrl_t c;
    c = '{tms_sel: TMS_ZERO, use_data: 1'b0, emit_if_away: 1'b0, jmp: JMP_DONE};
    if (upc < AddrResetLast) begin
      c.tms_sel = TMS_ONE;
      c.jmp     = JMP_NEXT;
    end else if (upc == AddrGoto) begin
      c.tms_sel      = TMS_PATH;
      c.emit_if_away = 1'b1;
      c.jmp          = JMP_LOOP;
    end else if (upc == AddrShift) begin
      c.tms_sel  = TMS_LAST;
      c.use_data = 1'b1;
    end
    return c;
  endfunction

  function automatic tap_state_t tap_next(tap_state_t s, logic tms);
    tap_state_t n;
    case (s)
      TAP_RESET:  n = tms ? TAP_RESET  : TAP_IDLE;
      TAP_IDLE:   n = tms ? TAP_SEL_DR : TAP_IDLE;
      TAP_SEL_DR: n = tms ? TAP_SEL_IR : TAP_CAP_DR;
      TAP_CAP_DR: n = tms ? TAP_EX1_DR : TAP_SH_DR;
      TAP_SH_DR:  n = tms ? TAP_EX1_DR : TAP_SH_DR;
      TAP_EX1_DR: n = tms ? TAP_UPD_DR : TAP_PAU_DR;
      TAP_PAU_DR: n = tms ? TAP_EX2_DR : TAP_PAU_DR;
      TAP_EX2_DR: n = tms ? TAP_UPD_DR : TAP_SH_DR;
      TAP_UPD_DR: n = tms ? TAP_SEL_DR : TAP_IDLE;
      TAP_SEL_IR: n = tms ? TAP_RESET  : TAP_CAP_IR;
      TAP_CAP_IR: n = tms ? TAP_EX1_IR : TAP_SH_IR;
      TAP_SH_IR:  n = tms ? TAP_EX1_IR : TAP_SH_IR;
      TAP_EX1_IR: n = tms ? TAP_UPD_IR : TAP_PAU_IR;
      TAP_PAU_IR: n = tms ? TAP_EX2_IR : TAP_PAU_IR;
      TAP_EX2_IR: n = tms ? TAP_UPD_IR : TAP_SH_IR;
      TAP_UPD_IR: n = tms ? TAP_SEL_DR : TAP_IDLE;
      default:    n = TAP_RESET;
    endcase
    return n;
  endfunction

  // TMS level that moves one step along the fixed path towards tgt.
  function automatic logic path_tms(tap_state_t s, tap_state_t tgt);
    logic z;
    case (s)
      TAP_RESET:  z = 1'b1;
      TAP_SEL_DR: z = tgt inside {[TAP_CAP_DR:TAP_UPD_DR]};
      TAP_CAP_DR: z = (tgt == TAP_SH_DR);
      TAP_EX1_DR: z = tgt inside {TAP_PAU_DR, TAP_EX2_DR, TAP_SH_DR};
      TAP_EX2_DR: z = tgt inside {TAP_SH_DR, TAP_EX1_DR, TAP_PAU_DR};
      TAP_UPD_DR: z = (tgt == TAP_IDLE);
      TAP_SEL_IR: z = tgt inside {[TAP_CAP_IR:TAP_UPD_IR]};
      TAP_CAP_IR: z = (tgt == TAP_SH_IR);
      TAP_EX1_IR: z = tgt inside {TAP_PAU_IR, TAP_EX2_IR, TAP_SH_IR};
      TAP_EX2_IR: z = tgt inside {TAP_SH_IR, TAP_EX1_IR, TAP_PAU_IR};
      TAP_UPD_IR: z = (tgt == TAP_IDLE);
      default:    z = 1'b0;
    endcase
    return !z;
  endfunction

endpackage

@@ rtl/core/jtn_seq.sv @@
// Microcode sequencer: micro-PC, pulse counter and jump logic.
// Depends on jtn_pkg for the ROM, control word and status structs.
`timescale 1ns / 1ps

module jtn_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  jtn_pkg::op_t      start_op,
  input  jtn_pkg::dp_stat_t dp_stat,
  output jtn_pkg::ctrl_t    ctrl,
  output jtn_pkg::seq_stat_t seq_stat,
  output logic              busy,
  output logic              finish
);

  logic                      busy_r, busy_nxt;
  logic [jtn_pkg::UpcW-1:0]  upc_r, upc_nxt;
  logic [jtn_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic                      step, emit, run_end;

  assign ctrl = jtn_pkg::ucode(upc_r);
  assign step = busy_r && dp_stat.slot_free;

  always_comb begin
    emit    = step && !(ctrl.emit_if_away && dp_stat.pos_at_tgt);
    run_end = 1'b0;
    case (ctrl.jmp)
      jtn_pkg::JMP_DONE: run_end = 1'b1;
      jtn_pkg::JMP_LOOP: run_end = dp_stat.nxt_at_tgt ||
                                   (cnt_r == jtn_pkg::CntW'(jtn_pkg::MaxPulses - 1));
      default:           run_end = 1'b0;
    endcase
    finish = step && (!emit || run_end);

    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = jtn_pkg::entry_addr(start_op);
      cnt_nxt  = '0;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      cnt_nxt = cnt_r + 1'b1;
      if (ctrl.jmp == jtn_pkg::JMP_NEXT) begin
        upc_nxt = upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy     = busy_r;
  assign seq_stat = '{emit: emit, run_end: run_end};

endmodule

@@ rtl/core/jtn_dp.sv @@
// Datapath: request latch, TAP position, config register and result register.
// Depends on jtn_pkg for TAP rules and control word types.
`timescale 1ns / 1ps

module jtn_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [3:0]         in_target_state,
  input  logic               in_tdi_bit,
  input  logic               in_expected_tdo,
  input  logic               in_care_bit,
  input  logic               in_last_bit,
  input  logic               cfg_we,
  input  logic               cfg_check_enable,
  input  jtn_pkg::ctrl_t     ctrl,
  input  jtn_pkg::seq_stat_t seq_stat,
  output jtn_pkg::dp_stat_t  dp_stat,
  output logic [3:0]         tap_pos,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_tms_out,
  output logic               out_tdi_out,
  output logic               out_check_flag,
  output logic               out_expect_out,
  output logic [3:0]         out_state_after,
  output logic               out_run_end
);

  jtn_pkg::tap_state_t tap_r, tap_nxt, tgt_r;
  logic tdi_r, exp_r, care_r, last_r, ce_r;
  logic out_valid_r, out_valid_nxt;
  logic tms_r, tdo_r, chk_r, expv_r, end_r;
  logic [3:0] st_r;
  logic tms, chk;

  always_comb begin
    case (ctrl.tms_sel)
      jtn_pkg::TMS_ONE:  tms = 1'b1;
      jtn_pkg::TMS_LAST: tms = last_r;
      jtn_pkg::TMS_PATH: tms = jtn_pkg::path_tms(tap_r, tgt_r);
      default:           tms = 1'b0;
    endcase
    tap_nxt = jtn_pkg::tap_next(tap_r, tms);
    chk     = ctrl.use_data && ce_r && care_r;
  end

  assign dp_stat = '{slot_free:  !out_valid_r || out_ready,
                     pos_at_tgt: (tap_r == tgt_r),
                     nxt_at_tgt: (tap_nxt == tgt_r)};

  assign out_valid_nxt = seq_stat.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r       <= jtn_pkg::TAP_RESET;
      ce_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (seq_stat.emit) begin
        tap_r <= tap_nxt;
      end
      if (cfg_we) begin
        ce_r <= cfg_check_enable;
      end
    end
  end

  // Payload: latch request fields and result fields, no reset needed.
  always_ff @(posedge clk) begin
    if (start) begin
      tgt_r  <= jtn_pkg::tap_state_t'(in_target_state);
      tdi_r  <= in_tdi_bit;
      exp_r  <= in_expected_tdo;
      care_r <= in_care_bit;
      last_r <= in_last_bit;
    end
    if (seq_stat.emit) begin
      tms_r  <= tms;
      tdo_r  <= ctrl.use_data && tdi_r;
      chk_r  <= chk;
      expv_r <= chk && exp_r;
      st_r   <= tap_nxt;
      end_r  <= seq_stat.run_end;
    end
  end

  assign tap_pos         = tap_r;
  assign out_valid       = out_valid_r;
  assign out_tms_out     = tms_r;
  assign out_tdi_out     = tdo_r;
  assign out_check_flag  = chk_r;
  assign out_expect_out  = expv_r;
  assign out_state_after = st_r;
  assign out_run_end     = end_r;

endmodule

@@ rtl/core/jtag_tap_navigator_shifter.sv @@
// A taken request is latched; the sequencer then steps, registering each pulse as a result.
// Throughput: one TCK result per clock while running and the consumer keeps up;
// a request holds the block from its accept through one step per pulse, a goto already
// at the target spending one step with no pulse; a held result not yet taken stalls the next step.
// Synchronous active-low reset: TAP position test-logic-reset, checking on, sequencer idle.
// Depends on jtn_pkg, jtn_seq, jtn_dp and jtag_tap_navigator_shifter_macros.svh.
`timescale 1ns / 1ps
`include "jtag_tap_navigator_shifter_macros.svh"

module jtag_tap_navigator_shifter (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_check_enable,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [3:0] in_target_state,
  input  logic       in_tdi_bit,
  input  logic       in_expected_tdo,
  input  logic       in_care_bit,
  input  logic       in_last_bit,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tms_out,
  output logic       out_tdi_out,
  output logic       out_check_flag,
  output logic       out_expect_out,
  output logic [3:0] out_state_after,
  output logic       out_run_end
);

  jtn_pkg::ctrl_t     ctrl;
  jtn_pkg::seq_stat_t seq_stat;
  jtn_pkg::dp_stat_t  dp_stat;
  logic               busy, finish, start;
  logic [3:0]         tap_pos;

  // The config register is a single flop; accept writes at any time.
  assign cfg_ready = 1'b1;

  // Take a new request only when the sequencer has run the last one out;
  // the result register lets the final result wait without holding this up.
  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  // Sequencer walks the microcode: reset runs five TMS-high steps then one
  // low, goto loops on one word until the target or the pulse limit,
  // shift and idle are single-step words.
  jtn_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_op (jtn_pkg::op_t'(in_operation)),
    .dp_stat  (dp_stat),
    .ctrl     (ctrl),
    .seq_stat (seq_stat),
    .busy     (busy),
    .finish   (finish)
  );

  // Datapath: advance the TAP position on each emitted pulse and hold the
  // pulse in the result register until the consumer takes it.
  jtn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_target_state  (in_target_state),
    .in_tdi_bit       (in_tdi_bit),
    .in_expected_tdo  (in_expected_tdo),
    .in_care_bit      (in_care_bit),
    .in_last_bit      (in_last_bit),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_check_enable (cfg_check_enable),
    .ctrl             (ctrl),
    .seq_stat         (seq_stat),
    .dp_stat          (dp_stat),
    .tap_pos          (tap_pos),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_tms_out      (out_tms_out),
    .out_tdi_out      (out_tdi_out),
    .out_check_flag   (out_check_flag),
    .out_expect_out   (out_expect_out),
    .out_state_after  (out_state_after),
    .out_run_end      (out_run_end)
  );

  // A pending non-final pulse means the request is still in the sequencer.
  `JTN_ASSERT_NOW(a_mid_run_busy, out_valid && !out_run_end, busy,
                  "non-final result held while sequencer idle")
  // The tracked position always matches the last emitted pulse.
  `JTN_ASSERT_NOW(a_pos_tracks_out, out_valid, out_state_after == tap_pos,
                  "TAP position disagrees with held result")
  // A request ends only on its final pulse or on an empty goto.
  `JTN_ASSERT_NEXT(a_finish_clean, finish,
                   !busy && (out_run_end || !$past(seq_stat.emit)),
                   "request ended without a final pulse")

endmodule
